/* design/albd_pkg.sv */
// Package with constants, types and helpers shared by the beat detector.
`timescale 1ns / 1ps

package albd_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_EFFECTS_EN = 2'd0,
        REG_COLOR_EN   = 2'd1,
        REG_SENS       = 2'd2
    } t_reg_idx;

    // Level and timer constants (level Q12, seconds Q16)
    localparam logic [12:0] LEVEL_ONE      = 13'd4096;
    localparam logic [12:0] QUIET_LEVEL    = 13'd492;
    localparam logic [12:0] BEAT_LEVEL_MIN = 13'd1024;
    localparam logic [19:0] TIMER_MAX      = 20'hFFFFF;
    localparam logic [19:0] QUIET_SECS     = 20'd26214;
    localparam logic [19:0] SINCE_RESET    = 20'd655360;
    localparam logic [16:0] UNITY_Q16      = 17'h10000;

    // Threshold bases scaled by 256 and sensitivity coefficients
    localparam logic signed [23:0] RISE_BASE_Q     = 24'sd125952;
    localparam logic signed [23:0] RISE_COEF       = 24'sd246;
    localparam logic signed [23:0] CONTRAST_BASE_Q = 24'sd188672;
    localparam logic signed [23:0] CONTRAST_COEF   = 24'sd410;
    localparam logic signed [29:0] COOL_BASE_Q     = 30'sd4194304;
    localparam logic signed [29:0] COOL_COEF       = 30'sd7864;

    // Hue to color constants
    localparam logic [8:0]  HUE_WRAP    = 9'd360;
    localparam logic [7:0]  CHAN_FULL   = 8'd255;
    localparam logic [7:0]  CHAN_LOW    = 8'd38;
    localparam logic [15:0] Q_BASE      = 16'd61200;
    localparam logic [15:0] T_BASE      = 16'd9180;
    localparam logic [15:0] HUE_SLOPE   = 16'd867;
    localparam logic [12:0] RECIP_15    = 13'd4370;

    // Colors
    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

    // One accepted word after level clamp and hue conversion
    typedef struct packed {
        logic [12:0] level;
        logic [15:0] dt;
        logic [23:0] rgb;
    } t_item;

    // Scale one color channel by a Q16 keep factor
    function automatic logic [7:0] fade_chan(input logic [7:0] ch, input logic [16:0] keep);
        logic [24:0] prod;
        prod = 25'(ch) * 25'(keep);
        return prod[23:16];
    endfunction

    // Divide a value below 65536 by 240 with a reciprocal multiply
    function automatic logic [7:0] div240(input logic [15:0] x);
        logic [24:0] prod;
        prod = 25'(x[15:4]) * 25'(RECIP_15);
        return prod[23:16];
    endfunction

endpackage

/* design/audio_level_beat_detector_unit.sv */
// Beat detector top level: stream ports, config registers, single-pass datapath.
`timescale 1ns / 1ps
// The accepted input word is held in the input register, and its result word is then
//   held in the result register.
// Throughput: one word per cycle while the result side is ready; the state update is
//   combinational between the two registers.
// Reset (synchronous, active low): clears both stage valids, loads the tracker
//   state (since_beat = 10 s, target color white) and the config defaults.
module audio_level_beat_detector_unit
    import albd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // meter_level[15:0], frame_time[31:16], random_hue[40:32]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // beat[0], intensity[13:1], quiet[14],
                                       // color_red[22:15], color_green[30:23],
                                       // color_blue[38:31]
);

    // Config registers
    logic       r_effects_en;
    logic       r_color_en;
    logic [9:0] r_sens;

    // Tracker state
    logic [12:0] r_last_level, n_last_level;
    logic [12:0] r_floor_level, n_floor_level;
    logic [19:0] r_since_beat, n_since_beat;
    logic [19:0] r_quiet_time, n_quiet_time;
    logic [12:0] r_beat_level, n_beat_level;
    logic [23:0] r_target, n_target;

    // Pipeline registers
    logic        r_in_vld;
    t_item       r_in, n_in;
    logic        r_out_vld;
    logic [39:0] r_out_data, n_out_data;
    logic        n_beat;
    logic        w_adv;
    logic        w_cfg_wr;
    t_reg_idx    w_reg;

    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    // Write config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effects_en <= 1'b1;
            r_color_en   <= 1'b0;
            r_sens       <= 10'd256;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_EFFECTS_EN: r_effects_en <= pwdata[0];
                REG_COLOR_EN:   r_color_en   <= pwdata[0];
                REG_SENS:       r_sens       <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read back config registers
    always_comb begin
        case (w_reg)
            REG_EFFECTS_EN: prdata = {31'd0, r_effects_en};
            REG_COLOR_EN:   prdata = {31'd0, r_color_en};
            REG_SENS:       prdata = {22'd0, r_sens};
            default:        prdata = 32'd0;
        endcase
    end

    // Handshake: advance the input word when the result register is free
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Clamp level and turn the hue into its beat color on entry
    always_comb begin
        logic [15:0] meter;
        logic [8:0]  hue;
        logic [2:0]  sector;
        logic [8:0]  rem9;
        logic [15:0] slope;
        logic [7:0]  q_val;
        logic [7:0]  t_val;
        meter = s_axis_tdata[15:0];
        hue   = s_axis_tdata[40:32];
        if (hue >= HUE_WRAP) hue = hue - HUE_WRAP;
        if      (hue >= 9'd300) sector = 3'd5;
        else if (hue >= 9'd240) sector = 3'd4;
        else if (hue >= 9'd180) sector = 3'd3;
        else if (hue >= 9'd120) sector = 3'd2;
        else if (hue >= 9'd60)  sector = 3'd1;
        else                    sector = 3'd0;
        rem9  = hue - 9'(sector) * 9'd60;
        slope = 16'(rem9[5:0]) * HUE_SLOPE;
        q_val = div240(Q_BASE - slope);
        t_val = div240(T_BASE + slope);
        n_in.level = (meter > 16'(LEVEL_ONE)) ? LEVEL_ONE : meter[12:0];
        n_in.dt    = s_axis_tdata[31:16];
        case (sector)
            3'd0:    n_in.rgb = {CHAN_FULL, t_val, CHAN_LOW};
            3'd1:    n_in.rgb = {q_val, CHAN_FULL, CHAN_LOW};
            3'd2:    n_in.rgb = {CHAN_LOW, CHAN_FULL, t_val};
            3'd3:    n_in.rgb = {CHAN_LOW, q_val, CHAN_FULL};
            3'd4:    n_in.rgb = {t_val, CHAN_LOW, CHAN_FULL};
            default: n_in.rgb = {CHAN_FULL, CHAN_LOW, q_val};
        endcase
    end

    // Single-pass state update and result build
    always_comb begin
        logic        [12:0] level;
        logic        [15:0] dt;
        logic signed [13:0] rise;
        logic        [18:0] a5;
        logic        [16:0] alpha;
        logic        [29:0] prod;
        logic        [12:0] floor_a;
        logic        [20:0] qsum;
        logic        [20:0] ssum;
        logic        [19:0] quiet_a;
        logic        [19:0] since_a;
        logic        [12:0] contrast;
        logic signed [11:0] s_sens;
        logic               rise_ok;
        logic               contrast_ok;
        logic               cool_ok;
        logic        [19:0] dt9;
        logic        [14:0] dec;
        logic        [12:0] bl;
        logic        [19:0] qd;
        logic        [21:0] f3;
        logic        [20:0] fh;
        logic        [16:0] keep;
        logic        [23:0] fade_old;
        logic        [23:0] fade_new;
        logic               quiet_flag;

        level  = r_in.level;
        dt     = r_in.dt;
        s_sens = $signed({2'b00, r_sens});

        // Rise against previous level
        rise = $signed({1'b0, level}) - $signed({1'b0, r_last_level});

        // Floor: follow drops at once, else glide up at 5 per second
        a5    = 19'(dt) * 19'd5;
        alpha = (a5 > 19'(UNITY_Q16)) ? UNITY_Q16 : a5[16:0];
        prod  = 30'(level - r_floor_level) * 30'(alpha);
        if (level < r_floor_level) floor_a = level;
        else                       floor_a = r_floor_level + prod[28:16];

        // Saturating timers
        qsum    = {1'b0, r_quiet_time} + 21'(dt);
        quiet_a = (level < QUIET_LEVEL) ? (qsum[20] ? TIMER_MAX : qsum[19:0]) : 20'd0;
        ssum    = {1'b0, r_since_beat} + 21'(dt);
        since_a = ssum[20] ? TIMER_MAX : ssum[19:0];

        // Beat tests with sensitivity-scaled thresholds
        contrast    = level - floor_a;
        rise_ok     = (24'(rise) * 24'sd256) > (RISE_BASE_Q - 24'(s_sens) * RISE_COEF);
        contrast_ok = ($signed({11'd0, contrast}) * 24'sd256)
                      > (CONTRAST_BASE_Q - 24'(s_sens) * CONTRAST_COEF);
        cool_ok     = ($signed({10'd0, since_a}) * 30'sd256)
                      > (COOL_BASE_Q - 30'(s_sens) * COOL_COEF);
        n_beat      = r_effects_en && rise_ok && contrast_ok && cool_ok
                      && (level > BEAT_LEVEL_MIN);

        // Intensity decay at 4.5 per second
        dt9 = 20'(dt) * 20'd9;
        dec = dt9[19:5];
        bl  = n_beat ? LEVEL_ONE : r_beat_level;

        // Fade both candidate colors in parallel, pick after the beat test
        qd         = quiet_a - QUIET_SECS;
        f3         = 22'(qd) * 22'd3;
        fh         = f3[21:1];
        keep       = UNITY_Q16 - ((fh > 21'(UNITY_Q16)) ? UNITY_Q16 : fh[16:0]);
        quiet_flag = quiet_a > QUIET_SECS;
        fade_old   = {fade_chan(r_target[23:16], keep), fade_chan(r_target[15:8], keep),
                      fade_chan(r_target[7:0], keep)};
        fade_new   = {fade_chan(r_in.rgb[23:16], keep), fade_chan(r_in.rgb[15:8], keep),
                      fade_chan(r_in.rgb[7:0], keep)};

        // Hold state unless effects are on
        n_last_level  = r_last_level;
        n_floor_level = r_floor_level;
        n_since_beat  = r_since_beat;
        n_quiet_time  = r_quiet_time;
        n_beat_level  = r_beat_level;
        n_target      = r_target;
        if (r_effects_en) begin
            n_last_level  = level;
            n_floor_level = n_beat ? level : floor_a;
            n_since_beat  = n_beat ? 20'd0 : since_a;
            n_quiet_time  = quiet_a;
            n_beat_level  = (15'(bl) > dec) ? (bl - dec[12:0]) : 13'd0;
            if (r_color_en) begin
                if (quiet_flag) n_target = n_beat ? fade_new : fade_old;
                else if (n_beat) n_target = r_in.rgb;
            end
        end

        n_out_data = {1'b0, n_target[7:0], n_target[15:8], n_target[23:16],
                      (n_quiet_time > QUIET_SECS), n_beat_level, n_beat};
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= n_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // Advance tracker state with each word moved to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level  <= 13'd0;
            r_floor_level <= 13'd0;
            r_since_beat  <= SINCE_RESET;
            r_quiet_time  <= 20'd0;
            r_beat_level  <= 13'd0;
            r_target      <= COLOR_WHITE;
        end else if (w_adv) begin
            r_last_level  <= n_last_level;
            r_floor_level <= n_floor_level;
            r_since_beat  <= n_since_beat;
            r_quiet_time  <= n_quiet_time;
            r_beat_level  <= n_beat_level;
            r_target      <= n_target;
        end
    end

    // Floor never climbs above the previous level
    a_floor_below_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_floor_level <= r_last_level)
        else $error("floor level above last level");

    // Intensity stays within one
    a_intensity_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat_level <= LEVEL_ONE)
        else $error("beat intensity above one");

    // A beat restarts the cooldown timer
    a_beat_clears_since: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_beat) |=> (r_since_beat == 20'd0 && r_out_data[0]))
        else $error("beat did not restart cooldown");

    // Disabled effects leave state untouched
    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_effects_en) |=> ($stable(r_last_level) && $stable(r_target)
                                      && $stable(r_since_beat)))
        else $error("state changed with effects disabled");

    // A result word is loaded whenever an input word advances
    a_adv_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("advanced word lost");

endmodule

/* tb/sv/albd_beat_checker.sv */
// Checker for the beat detector: tracks registers, predicts each result word, compares.
`timescale 1ns / 1ps

module albd_beat_checker
    import albd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration bus, watched for writes
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    // Level words into the block
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,   // meter_level[15:0], frame_time[31:16], random_hue[40:32]
    // Result words out of the block
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,  // beat[0], intensity[13:1], quiet[14],
                                     // color_red[22:15], color_green[30:23], color_blue[38:31]
    output int          o_errors,
    output int          o_pending,
    output int          o_beats
);

    // Fixed-point constants: level Q12, seconds Q16, thresholds scaled by 256
    localparam int LEVEL_FULL     = 4096;
    localparam int TIMER_TOP      = 1048575;
    localparam int QUIET_LIMIT    = 492;
    localparam int QUIET_HOLD     = 26214;
    localparam int HIT_FLOOR      = 1024;
    localparam int SINCE_START    = 655360;
    localparam int RISE_Q8        = 125952;
    localparam int RISE_SLOPE     = 246;
    localparam int CONTRAST_Q8    = 188672;
    localparam int CONTRAST_SLOPE = 410;
    localparam int COOL_Q8        = 4194304;
    localparam int COOL_SLOPE     = 7864;
    localparam int UNITY          = 65536;
    localparam int CHAN_LOW       = 38;

    typedef struct packed {
        logic        beat;
        logic [12:0] intensity;
        logic        quiet;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_level_result;

    // Register copies
    bit          effects_on;
    bit          color_on;
    int          sens;

    // Tracker state
    int          prev_level;
    int          floor_lvl;
    int          since_hit;
    int          quiet_run;
    int          hit_level;
    logic [23:0] target_rgb;

    t_level_result pending_results[$];
    int            n_errors;
    int            n_results;

    assign o_errors = n_errors;

    // Add a frame time to a timer, saturating at the timer width
    function automatic int timer_add(input int base, input int dt);
        return (base + dt > TIMER_TOP) ? TIMER_TOP : base + dt;
    endfunction

    // Turn a hue in degrees into a fully bright color with 0.85 saturation
    function automatic logic [23:0] hue_color(input int hue_in);
        int h;
        int part;
        int q;
        int t;
        h = (hue_in >= 360) ? hue_in - 360 : hue_in;
        part = h % 60;
        q = (61200 - 867 * part) / 240;
        t = (9180 + 867 * part) / 240;
        case (h / 60)
            0:       return {8'd255, 8'(t), 8'(CHAN_LOW)};
            1:       return {8'(q), 8'd255, 8'(CHAN_LOW)};
            2:       return {8'(CHAN_LOW), 8'd255, 8'(t)};
            3:       return {8'(CHAN_LOW), 8'(q), 8'd255};
            4:       return {8'(t), 8'(CHAN_LOW), 8'd255};
            default: return {8'd255, 8'(CHAN_LOW), 8'(q)};
        endcase
    endfunction

    // Scale one channel by a Q16 keep factor
    function automatic logic [7:0] dim_chan(input logic [7:0] ch, input int keep);
        return 8'((int'(ch) * keep) >> 16);
    endfunction

    task automatic reset_tracker();
        effects_on = 1'b1;
        color_on   = 1'b0;
        sens       = 256;
        prev_level = 0;
        floor_lvl  = 0;
        since_hit  = SINCE_START;
        quiet_run  = 0;
        hit_level  = 0;
        target_rgb = 24'hFFFFFF;
        pending_results.delete();
    endtask

    // Advance the tracker by one level word and form the result it shows
    task automatic track_level(input logic [15:0] meter, input logic [15:0] frame_dt,
                               input logic [8:0] hue, output t_level_result res);
        int  lvl;
        int  dt;
        int  rise;
        int  contrast;
        int  alpha;
        int  fade;
        int  keep;
        int  decay;
        bit  hit;
        hit = 1'b0;
        if (effects_on) begin
            dt  = int'(frame_dt);
            lvl = (int'(meter) > LEVEL_FULL) ? LEVEL_FULL : int'(meter);

            rise = lvl - prev_level;
            prev_level = lvl;

            // Floor drops at once, rises at a rate of five per second
            if (lvl < floor_lvl) begin
                floor_lvl = lvl;
            end else begin
                alpha = (5 * dt > UNITY) ? UNITY : 5 * dt;
                floor_lvl = floor_lvl + (((lvl - floor_lvl) * alpha) >> 16);
            end

            quiet_run = (lvl < QUIET_LIMIT) ? timer_add(quiet_run, dt) : 0;
            since_hit = timer_add(since_hit, dt);
            contrast  = lvl - floor_lvl;

            if (rise * 256 > RISE_Q8 - sens * RISE_SLOPE
                    && contrast * 256 > CONTRAST_Q8 - sens * CONTRAST_SLOPE
                    && lvl > HIT_FLOOR
                    && since_hit * 256 > COOL_Q8 - sens * COOL_SLOPE) begin
                hit       = 1'b1;
                since_hit = 0;
                hit_level = LEVEL_FULL;
                floor_lvl = lvl;
            end

            // Intensity decays at 4.5 per second
            decay = (dt * 9) >> 5;
            hit_level = (hit_level > decay) ? hit_level - decay : 0;

            if (color_on) begin
                if (hit) begin
                    target_rgb = hue_color(int'(hue));
                end
                if (quiet_run > QUIET_HOLD) begin
                    fade = (3 * (quiet_run - QUIET_HOLD)) >> 1;
                    if (fade > UNITY) begin
                        fade = UNITY;
                    end
                    keep = UNITY - fade;
                    target_rgb = {dim_chan(target_rgb[23:16], keep),
                                  dim_chan(target_rgb[15:8], keep),
                                  dim_chan(target_rgb[7:0], keep)};
                end
            end
        end
        res.beat      = hit;
        res.intensity = 13'(hit_level);
        res.quiet     = (quiet_run > QUIET_HOLD);
        res.red       = target_rgb[23:16];
        res.green     = target_rgb[15:8];
        res.blue      = target_rgb[7:0];
    endtask

    task automatic flag_error(input string what, input int want, input int got);
        if (n_errors < 10) begin
            $display("[%0t] result %0d: %s expected %0d, got %0d",
                     $realtime, n_results, what, want, got);
        end
        n_errors++;
    endtask

    task automatic compare_result(input t_level_result want, input t_level_result got);
        if (want.beat != got.beat)           flag_error("beat", want.beat, got.beat);
        if (want.intensity != got.intensity) flag_error("intensity", want.intensity, got.intensity);
        if (want.quiet != got.quiet)         flag_error("quiet", want.quiet, got.quiet);
        if (want.red != got.red)             flag_error("color_red", want.red, got.red);
        if (want.green != got.green)         flag_error("color_green", want.green, got.green);
        if (want.blue != got.blue)           flag_error("color_blue", want.blue, got.blue);
    endtask

    initial begin
        n_errors  = 0;
        n_results = 0;
        o_pending = 0;
        o_beats   = 0;
        reset_tracker();
    end

    // Watch all three channels; results are matched before new words are queued
    always @(posedge i_clk) begin
        t_level_result want;
        t_level_result got;
        if (!i_rst_n) begin
            reset_tracker();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_EFFECTS_EN: effects_on = i_pwdata[0];
                    REG_COLOR_EN:   color_on   = i_pwdata[0];
                    REG_SENS:       sens       = int'(i_pwdata[9:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.beat      = i_out_data[0];
                got.intensity = i_out_data[13:1];
                got.quiet     = i_out_data[14];
                got.red       = i_out_data[22:15];
                got.green     = i_out_data[30:23];
                got.blue      = i_out_data[38:31];
                if (pending_results.size() == 0) begin
                    flag_error("word with nothing pending, beat", 0, got.beat);
                end else begin
                    want = pending_results.pop_front();
                    compare_result(want, got);
                end
                n_results++;
            end
            if (i_in_valid && i_in_ready) begin
                track_level(i_in_data[15:0], i_in_data[31:16], i_in_data[40:32], want);
                pending_results.push_back(want);
                if (want.beat) begin
                    o_beats <= o_beats + 1;
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

/* tb/sv/audio_level_beat_detector_unit_tb.sv */
// Testbench top for the beat detector: clock, reset, stimulus, stall control and verdict.
`timescale 1ns / 1ps

module audio_level_beat_detector_unit_tb;
    import albd_pkg::*;

    localparam int IDLE_LIMIT = 500;
    localparam int N_PHASES   = 11;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = 4'd0;
    logic [31:0] pwdata        = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = 48'd0;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] prdata;
    wire         pready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [39:0] m_axis_tdata;

    int n_errors;
    int n_pending;
    int n_beats;
    int n_words      = 0;
    int n_settings   = 0;
    int idle_cycles  = 0;
    int quiet_left   = 0;
    bit long_frames  = 1'b0;
    bit gaps_on      = 1'b1;

    // Register settings per phase: effects, color, sensitivity (-1 = random), words
    int phase_fx[N_PHASES]    = '{1, 1, 1, 1, 0, 1, 1, 0, 1, 1, 1};
    int phase_color[N_PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0, 1, 0, 1};
    int phase_sens[N_PHASES]  = '{256, 0, 512, 128, 300, 1023, 700, 0, -1, 384, 64};
    int phase_words[N_PHASES] = '{130, 130, 130, 100, 40, 130, 100, 30, 130, 100, 110};

    audio_level_beat_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    albd_beat_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (n_errors),
        .o_pending   (n_pending),
        .o_beats     (n_beats)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Write one register: setup cycle, then access cycle until pready
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_registers(input int fx, input int color, input int sens);
        reg_write(REG_EFFECTS_EN, 32'(fx));
        reg_write(REG_COLOR_EN, 32'(color));
        reg_write(REG_SENS, 32'(sens));
        n_settings++;
    endtask

    // Offer one level word after a random gap and hold it until taken
    task automatic send_word(input logic [15:0] lvl, input logic [15:0] dt,
                             input logic [8:0] hue);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, hue, dt, lvl};
        do @(posedge i_clk); while (!s_axis_tready);
        n_words++;
    endtask

    // Drop valid and wait until every result word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Draw a word: frame-rate music with hits, quiet runs, or raw noise
    task automatic random_word(output logic [15:0] lvl, output logic [15:0] dt,
                               output logic [8:0] hue);
        int pick;
        hue = 9'($urandom_range(0, 359));
        if (quiet_left == 0 && $urandom_range(0, 99) < 8) begin
            quiet_left  = $urandom_range(3, 20);
            long_frames = ($urandom_range(0, 3) == 0);
        end
        if (quiet_left > 0) begin
            quiet_left--;
            lvl = 16'($urandom_range(0, 520));
            dt  = long_frames ? 16'($urandom_range(60000, 65535))
                              : 16'($urandom_range(2000, 40000));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                dt  = 16'($urandom_range(400, 3000));
                lvl = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1200, 4600))
                                                  : 16'($urandom_range(0, 1400));
            end else begin
                lvl = 16'($urandom);
                dt  = 16'($urandom);
                hue = 9'($urandom);
            end
        end
    endtask

    // Result side: random stall before each word
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Watchdog: stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Main sequence
    initial begin
        logic [15:0] lvl;
        logic [15:0] dt;
        logic [8:0]  hue;
        int          sens;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with colour on and default sensitivity
        gaps_on = 1'b1;
        set_registers(1, 1, 256);
        send_word(16'd0, 16'd1092, 9'd0);
        send_word(16'hFFFF, 16'd1092, 9'd0);     // clamped hit, red sector
        send_word(16'd4097, 16'd1092, 9'd60);    // clamped, no rise, cooling down
        send_word(16'd0, 16'd20000, 9'd60);
        send_word(16'd1024, 16'd1092, 9'd60);    // level not above the hit floor
        send_word(16'd0, 16'd20000, 9'd60);
        send_word(16'd1025, 16'd1092, 9'd119);   // just above the floor, end of sector
        send_word(16'd0, 16'd20000, 9'd0);
        send_word(16'd4096, 16'd1092, 9'd180);
        send_word(16'd0, 16'd20000, 9'd0);
        send_word(16'd3000, 16'd1092, 9'd240);
        send_word(16'd0, 16'd20000, 9'd0);
        send_word(16'd3000, 16'd1092, 9'd359);
        send_word(16'd0, 16'd20000, 9'd0);
        send_word(16'd3000, 16'd1092, 9'h1FF);   // hue past 360 wraps once
        send_word(16'd491, 16'd0, 9'd0);         // quiet edge, zero frame time
        send_word(16'd492, 16'd1092, 9'd0);
        // Long silence: fade to black and let the beat timer run
        repeat (8) send_word(16'd0, 16'hFFFF, 9'd0);
        drain();

        // Random phases over a range of register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            sens = (phase_sens[ph] < 0) ? $urandom_range(0, 1023) : phase_sens[ph];
            set_registers(phase_fx[ph], phase_color[ph], sens);
            quiet_left = 0;
            for (int k = 0; k < phase_words[ph]; k++) begin
                if (k % 40 == 0) begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                end
                random_word(lvl, dt, hue);
                send_word(lvl, dt, hue);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("covered %0d level words over %0d register settings, %0d beats predicted",
                 n_words, n_settings, n_beats);
        if (n_errors == 0 && n_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
